[src/unique_value_stack_engine_unit_defines.svh]
// Assertion macros for the unique value stack engine.
// Used by the top level only; define NO_ASSERTIONS to drop them.
`ifndef UNIQUE_VALUE_STACK_ENGINE_UNIT_DEFINES_SVH
`define UNIQUE_VALUE_STACK_ENGINE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define UVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UVS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/uvs_pkg.sv]
// Types and codes for the unique value stack engine.
// No dependencies.
`default_nettype none
package uvs_pkg;
    typedef enum logic [2:0] {
        FN_PUSH = 3'd0, FN_POP = 3'd1, FN_SWAP = 3'd2, FN_DELETE = 3'd3,
        FN_SEARCH = 3'd4, FN_REVERSE = 3'd5, FN_SORT = 3'd6, FN_QUERY = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_DUPLICATE = 3'd2,
        ST_EMPTY = 3'd3, ST_NOT_FOUND = 3'd4, ST_FEW = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] operand;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic [3:0]         match_index;
        logic [4:0]         count;
        logic signed [31:0] top_value;
        logic               top_valid;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
        S_REV_RD, S_REV_RD2, S_REV_WR, S_REV_WR2,
        S_SORT_RD, S_SORT_CMP, S_SORT_WR,
        S_TOP_RD, S_TOP_WAIT, S_DONE
    } state_t;

    typedef struct packed {
        logic        we;
        logic [31:0] wdata;
    } mem_wr_t;
endpackage
`default_nettype wire

[src/uvs_mem.sv]
// Entry memory of the stack: one write port, one registered read port.
// Depends on uvs_pkg.
`default_nettype none
module uvs_mem #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire logic            clk,
    input  wire uvs_pkg::mem_wr_t wr,
    input  wire logic [AW-1:0]   waddr,
    input  wire logic [AW-1:0]   raddr,
    output logic [31:0]          rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[waddr] <= wr.wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/unique_value_stack_engine_unit.sv]
// Unique value stack engine: one result word per command word.
// Push, delete and search first scan the held entries for the operand; delete then shifts
// the entries above the match down, swap and reverse exchange entries in pairs, and sort
// inserts each entry above the bottom into place, all through the single entry memory.
// Next command is taken the cycle after the result word leaves. Reset clears fill and control.
`default_nettype none
`include "unique_value_stack_engine_unit_defines.svh"
module unique_value_stack_engine_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire uvs_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output uvs_pkg::out_word_t     out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    uvs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [2:0]    func_reg, func_next;
    logic [31:0]   opnd_reg, opnd_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [31:0]   t_reg, t_next;
    logic [31:0]   u_reg, u_next;
    logic [2:0]    st_reg, st_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          ov_reg, ov_next;
    uvs_pkg::out_word_t od_reg, od_next;

    uvs_pkg::mem_wr_t wr;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rdata;
    logic          sort_shift;

    uvs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .wr(wr), .waddr(waddr), .raddr(raddr), .rdata(rdata)
    );

    logic accept;
    assign in_stall  = (state_reg != uvs_pkg::S_IDLE) || ov_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic lt_s(input logic [31:0] a, input logic [31:0] b);
        lt_s = $signed(a) < $signed(b);
    endfunction

    assign sort_shift = (j_reg != '0) && lt_s(t_reg, rdata);

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        func_next = func_reg;
        opnd_next = opnd_reg;
        i_next = i_reg;
        j_next = j_reg;
        pos_next = pos_reg;
        t_next = t_reg;
        u_next = u_reg;
        st_next = st_reg;
        val_next = val_reg;
        idx_next = idx_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            uvs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_data.func;
                    opnd_next = in_data.operand;
                    st_next = uvs_pkg::ST_OK;
                    val_next = 32'd0;
                    idx_next = '0;
                    i_next = '0;
                    pos_next = fill_reg;
                    priority case (in_data.func)
                        uvs_pkg::FN_PUSH, uvs_pkg::FN_DELETE, uvs_pkg::FN_SEARCH:
                        begin
                            val_next = in_data.operand;
                            state_next = uvs_pkg::S_SCAN;
                        end
                        uvs_pkg::FN_REVERSE:
                        begin
                            j_next = fill_reg - 1'b1;
                            state_next = uvs_pkg::S_REV_RD;
                        end
                        uvs_pkg::FN_SORT:
                        begin
                            i_next = CW'(1);
                            state_next = uvs_pkg::S_SORT_RD;
                        end
                        default:
                        begin
                            state_next = uvs_pkg::S_DECIDE;
                        end
                    endcase
                end
            end
            uvs_pkg::S_SCAN:
            begin
                if (i_reg >= fill_reg)
                begin
                    state_next = uvs_pkg::S_DECIDE;
                end
                else
                begin
                    state_next = uvs_pkg::S_SCAN_WAIT;
                end
            end
            uvs_pkg::S_SCAN_WAIT:
            begin
                if (rdata == opnd_reg)
                begin
                    pos_next = i_reg;
                end
                i_next = i_reg + 1'b1;
                state_next = uvs_pkg::S_SCAN;
            end
            uvs_pkg::S_DECIDE:
            begin
                state_next = uvs_pkg::S_TOP_RD;
                priority case (func_reg)
                    uvs_pkg::FN_PUSH:
                    begin
                        if (pos_reg < fill_reg)
                        begin
                            st_next = uvs_pkg::ST_DUPLICATE;
                        end
                        else if (fill_reg >= CW'(DEPTH))
                        begin
                            st_next = uvs_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    uvs_pkg::FN_DELETE, uvs_pkg::FN_SEARCH:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = uvs_pkg::ST_EMPTY;
                        end
                        else if (pos_reg >= fill_reg)
                        begin
                            st_next = uvs_pkg::ST_NOT_FOUND;
                        end
                        else if (func_reg == uvs_pkg::FN_SEARCH)
                        begin
                            idx_next = pos_reg;
                        end
                        else
                        begin
                            i_next = pos_reg;
                            state_next = uvs_pkg::S_SHIFT_RD;
                        end
                    end
                    uvs_pkg::FN_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = uvs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            fill_next = fill_reg - 1'b1;
                            ov_next = 1'b0;
                            i_next = '1;
                            state_next = uvs_pkg::S_TOP_WAIT;
                        end
                    end
                    uvs_pkg::FN_SWAP:
                    begin
                        if (fill_reg < CW'(2))
                        begin
                            st_next = uvs_pkg::ST_FEW;
                        end
                        else
                        begin
                            i_next = fill_reg - CW'(2);
                            j_next = fill_reg - 1'b1;
                            state_next = uvs_pkg::S_REV_RD;
                        end
                    end
                    default:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = uvs_pkg::ST_EMPTY;
                        end
                    end
                endcase
            end
            uvs_pkg::S_SHIFT_RD:
            begin
                if (i_reg + 1'b1 >= fill_reg)
                begin
                    fill_next = fill_reg - 1'b1;
                    state_next = uvs_pkg::S_TOP_RD;
                end
                else
                begin
                    state_next = uvs_pkg::S_SHIFT_WR;
                end
            end
            uvs_pkg::S_SHIFT_WR:
            begin
                i_next = i_reg + 1'b1;
                state_next = uvs_pkg::S_SHIFT_RD;
            end
            uvs_pkg::S_REV_RD:
            begin
                if (fill_reg == '0)
                begin
                    st_next = uvs_pkg::ST_EMPTY;
                    state_next = uvs_pkg::S_TOP_RD;
                end
                else if (i_reg >= j_reg)
                begin
                    state_next = uvs_pkg::S_TOP_RD;
                end
                else
                begin
                    state_next = uvs_pkg::S_REV_RD2;
                end
            end
            uvs_pkg::S_REV_RD2:
            begin
                t_next = rdata;
                state_next = uvs_pkg::S_REV_WR;
            end
            uvs_pkg::S_REV_WR:
            begin
                state_next = uvs_pkg::S_REV_WR2;
            end
            uvs_pkg::S_REV_WR2:
            begin
                i_next = i_reg + 1'b1;
                j_next = j_reg - 1'b1;
                state_next = uvs_pkg::S_REV_RD;
            end
            uvs_pkg::S_SORT_RD:
            begin
                if (i_reg >= fill_reg)
                begin
                    state_next = uvs_pkg::S_TOP_RD;
                end
                else
                begin
                    j_next = i_reg;
                    state_next = uvs_pkg::S_SORT_CMP;
                    pos_next = '0;
                end
            end
            uvs_pkg::S_SORT_CMP:
            begin
                if (pos_reg == '0)
                begin
                    t_next = rdata;
                    pos_next = CW'(1);
                end
                state_next = uvs_pkg::S_SORT_WR;
            end
            uvs_pkg::S_SORT_WR:
            begin
                if (sort_shift)
                begin
                    j_next = j_reg - 1'b1;
                    state_next = uvs_pkg::S_SORT_CMP;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = uvs_pkg::S_SORT_RD;
                end
            end
            uvs_pkg::S_TOP_RD:
            begin
                i_next = '0;
                state_next = uvs_pkg::S_TOP_WAIT;
            end
            uvs_pkg::S_TOP_WAIT:
            begin
                if (i_reg == '1)
                begin
                    val_next = rdata;
                    state_next = uvs_pkg::S_TOP_RD;
                end
                else
                begin
                    u_next = rdata;
                    state_next = uvs_pkg::S_DONE;
                end
            end
            uvs_pkg::S_DONE:
            begin
                if (!ov_reg)
                begin
                    od_next.status = st_reg;
                    od_next.count = 5'(fill_reg);
                    od_next.match_index = 4'(idx_reg);
                    od_next.top_valid = (fill_reg != '0);
                    od_next.top_value = (fill_reg != '0) ? u_reg : 32'd0;
                    od_next.out_value = val_reg;
                    if ((func_reg == uvs_pkg::FN_SWAP || func_reg == uvs_pkg::FN_QUERY)
                        && st_reg == uvs_pkg::ST_OK)
                    begin
                        od_next.out_value = u_reg;
                    end
                    ov_next = 1'b1;
                    state_next = uvs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = uvs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr.we = 1'b0;
        wr.wdata = 32'd0;
        waddr = '0;
        raddr = '0;
        unique case (state_reg)
            uvs_pkg::S_SCAN:
            begin
                if (i_reg < fill_reg)
                begin
                    raddr = i_reg[AW-1:0];
                end
            end
            uvs_pkg::S_DECIDE:
            begin
                if (func_reg == uvs_pkg::FN_PUSH && pos_reg >= fill_reg
                    && fill_reg < CW'(DEPTH))
                begin
                    wr.we = 1'b1;
                    wr.wdata = opnd_reg;
                    waddr = fill_reg[AW-1:0];
                end
                if (func_reg == uvs_pkg::FN_POP && fill_reg != '0)
                begin
                    raddr = AW'(fill_reg - 1'b1);
                end
            end
            uvs_pkg::S_SHIFT_RD:
            begin
                if (i_reg + 1'b1 < fill_reg)
                begin
                    raddr = AW'(i_reg + 1'b1);
                end
            end
            uvs_pkg::S_SHIFT_WR:
            begin
                wr.we = 1'b1;
                wr.wdata = rdata;
                waddr = i_reg[AW-1:0];
            end
            uvs_pkg::S_REV_RD:
            begin
                if (fill_reg != '0 && i_reg < j_reg)
                begin
                    raddr = i_reg[AW-1:0];
                end
            end
            uvs_pkg::S_REV_RD2:
            begin
                raddr = j_reg[AW-1:0];
            end
            uvs_pkg::S_REV_WR:
            begin
                wr.we = 1'b1;
                wr.wdata = rdata;
                waddr = i_reg[AW-1:0];
            end
            uvs_pkg::S_REV_WR2:
            begin
                wr.we = 1'b1;
                wr.wdata = t_reg;
                waddr = j_reg[AW-1:0];
            end
            uvs_pkg::S_SORT_RD:
            begin
                if (i_reg < fill_reg)
                begin
                    raddr = i_reg[AW-1:0];
                end
            end
            uvs_pkg::S_SORT_CMP:
            begin
                raddr = AW'(j_reg - 1'b1);
            end
            uvs_pkg::S_SORT_WR:
            begin
                wr.we = 1'b1;
                wr.wdata = sort_shift ? rdata : t_reg;
                waddr = j_reg[AW-1:0];
            end
            uvs_pkg::S_TOP_RD:
            begin
                raddr = AW'(fill_reg - 1'b1);
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uvs_pkg::S_IDLE;
            fill_reg <= '0;
            ov_reg <= 1'b0;
            j_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            ov_reg <= ov_next;
            j_reg <= j_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        opnd_reg <= opnd_next;
        i_reg <= i_next;
        t_reg <= t_next;
        u_reg <= u_next;
        st_reg <= st_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        od_reg <= od_next;
    end

    `UVS_ASSERT_IMPL(a_fill_max, clk, rst_n, 1'b1, fill_reg <= CW'(DEPTH))
    `UVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `UVS_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_reg != uvs_pkg::S_IDLE, in_stall)
endmodule
`default_nettype wire
